// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property that is ignored while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/mnos_pkg.sv =====
// Types and constants for the MIDI note-off scheduler.
package mnos_pkg;

   localparam int QueueDepth = 32;
   localparam int IdxWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] StNoteOn   = 8'd144;
   localparam logic [7:0] StNoteOff  = 8'd128;
   localparam logic [7:0] StControl  = 8'd176;
   localparam logic [6:0] CcAllOff   = 7'h7b;
   localparam int         NumChannels = 16;

   typedef enum logic [1:0] {
      ReqPlay   = 2'd0,
      ReqTick   = 2'd1,
      ReqAllOff = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      StIdle,
      StPlay,
      StScanRead,
      StScanCheck,
      StScanFlush,
      StAllOff
   } state_type;

   typedef struct packed {
      logic [31:0] due_tick;
      logic [3:0]  channel;
      logic [6:0]  note;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

endpackage

// ===== src/mnos_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mnos_ram #(
   parameter int DataWidth = 8,
   parameter int Depth     = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [DataWidth-1:0]                       wr_data,
   input  logic                                       rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [DataWidth-1:0]                       rd_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   // write port, then registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/midi_note_off_scheduler_core.sv =====
// Note-off scheduler: one request at a time, sequenced over one store with a write and a read port.
// Play: accepted in Idle, then StPlay loads the note-on into the output register; dropped without port_ready.
// Tick: each stored entry is read (StScanRead) and compared (StScanCheck), then StScanFlush; none stored: stays idle.
// All-off: after the accept cycle, 16 controller results, one per cycle while the output does not stall.
// An output stall holds the sequence; the next request is taken once the last result is loaded.
// Synchronous reset empties the store (count only), clears port_ready and the output valid.
module midi_note_off_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   input  logic [31:0] req_off_tick,
   input  logic [31:0] req_now_tick,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_data_one,
   output logic [6:0]  rsp_data_two,
   output logic        rsp_last_of_run,
   output logic        rsp_queue_overflow,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_port_ready
);

   localparam int CW = mnos_pkg::CountWidth;
   localparam int IW = mnos_pkg::IdxWidth;

   mnos_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          pend_ff, pend_in;
   logic [3:0]    pend_ch_ff, pend_ch_in;
   logic [6:0]    pend_note_ff, pend_note_in;
   logic [3:0]    cc_chan_ff, cc_chan_in;
   logic          port_ready_ff;
   logic          rsp_valid_ff;

   // held request fields
   logic [3:0]    cmd_ch_ff;
   logic [6:0]    cmd_note_ff;
   logic [6:0]    cmd_vel_ff;
   logic [31:0]   cmd_off_ff;
   logic [31:0]   cmd_now_ff;

   // output register payload
   logic [7:0]    out_status_ff;
   logic [6:0]    out_d1_ff, out_d2_ff;
   logic          out_last_ff, out_ovf_ff;

   logic          req_accept;
   logic          out_free;
   logic          out_load;
   logic [7:0]    out_status;
   logic [6:0]    out_d1, out_d2;
   logic          out_last, out_ovf;

   logic                 ram_wr_en, ram_rd_en;
   logic [IW-1:0]        ram_wr_addr, ram_rd_addr;
   mnos_pkg::entry_type  ram_wr_data, rd_entry;
   logic [mnos_pkg::EntryWidth-1:0] ram_rd_data;

   assign req_stall  = (state_ff != mnos_pkg::StIdle);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rd_entry   = mnos_pkg::entry_type'(ram_rd_data);

   mnos_ram #(
      .DataWidth (mnos_pkg::EntryWidth),
      .Depth     (mnos_pkg::QueueDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer: next state, store access and result loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = pend_ff;
      pend_ch_in   = pend_ch_ff;
      pend_note_in = pend_note_ff;
      cc_chan_in   = cc_chan_ff;
      out_load     = 1'b0;
      out_status   = mnos_pkg::StNoteOff | {4'h0, pend_ch_ff};
      out_d1       = pend_note_ff;
      out_d2       = 7'd0;
      out_last     = 1'b0;
      out_ovf      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IW-1:0];
      ram_wr_data  = '{due_tick: cmd_off_ff, channel: cmd_ch_ff, note: cmd_note_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_idx_ff[IW-1:0];

      case (state_ff)
         mnos_pkg::StIdle: begin
            if (req_accept) begin
               case (req_type)
                  mnos_pkg::ReqPlay: begin
                     if (port_ready_ff) begin
                        state_in = mnos_pkg::StPlay;
                     end
                  end
                  mnos_pkg::ReqTick: begin
                     scan_idx_in = '0;
                     wr_idx_in   = '0;
                     pend_in     = 1'b0;
                     if (count_ff != '0) begin
                        state_in = mnos_pkg::StScanRead;
                     end
                  end
                  mnos_pkg::ReqAllOff: begin
                     cc_chan_in = '0;
                     state_in   = mnos_pkg::StAllOff;
                  end
                  default: begin
                     // drop the unused request code
                  end
               endcase
            end
         end

         mnos_pkg::StPlay: begin
            // emit the note-on and store the note-off if there is room
            if (out_free) begin
               out_load   = 1'b1;
               out_status = mnos_pkg::StNoteOn | {4'h0, cmd_ch_ff};
               out_d1     = cmd_note_ff;
               out_d2     = cmd_vel_ff;
               out_last   = 1'b1;
               if (count_ff == CW'(mnos_pkg::QueueDepth)) begin
                  out_ovf = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
               state_in = mnos_pkg::StIdle;
            end
         end

         mnos_pkg::StScanRead: begin
            ram_rd_en = 1'b1;
            state_in  = mnos_pkg::StScanCheck;
         end

         mnos_pkg::StScanCheck: begin
            if (rd_entry.due_tick == cmd_now_ff) begin
               // hold one due entry back so the final one can carry last_of_run
               if (!pend_ff || out_free) begin
                  out_load     = pend_ff;
                  pend_in      = 1'b1;
                  pend_ch_in   = rd_entry.channel;
                  pend_note_in = rd_entry.note;
                  scan_idx_in  = scan_idx_ff + CW'(1);
                  state_in     = (scan_idx_ff + CW'(1) == count_ff) ?
                                 mnos_pkg::StScanFlush : mnos_pkg::StScanRead;
               end
            end else begin
               // compact the kept entry down to the write index
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_idx_ff[IW-1:0];
               ram_wr_data = rd_entry;
               wr_idx_in   = wr_idx_ff + CW'(1);
               scan_idx_in = scan_idx_ff + CW'(1);
               state_in    = (scan_idx_ff + CW'(1) == count_ff) ?
                             mnos_pkg::StScanFlush : mnos_pkg::StScanRead;
            end
         end

         mnos_pkg::StScanFlush: begin
            if (!pend_ff) begin
               count_in = wr_idx_ff;
               state_in = mnos_pkg::StIdle;
            end else if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               pend_in  = 1'b0;
               count_in = wr_idx_ff;
               state_in = mnos_pkg::StIdle;
            end
         end

         mnos_pkg::StAllOff: begin
            // one controller-123 message per channel
            count_in = '0;
            if (out_free) begin
               out_load   = 1'b1;
               out_status = mnos_pkg::StControl | {4'h0, cc_chan_ff};
               out_d1     = mnos_pkg::CcAllOff;
               out_last   = (cc_chan_ff == 4'(mnos_pkg::NumChannels - 1));
               cc_chan_in = cc_chan_ff + 4'd1;
               if (out_last) begin
                  state_in = mnos_pkg::StIdle;
               end
            end
         end

         default: begin
            state_in = mnos_pkg::StIdle;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mnos_pkg::StIdle;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         wr_idx_ff     <= '0;
         pend_ff       <= 1'b0;
         cc_chan_ff    <= '0;
         port_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         wr_idx_ff   <= wr_idx_in;
         pend_ff     <= pend_in;
         cc_chan_ff  <= cc_chan_in;
         if (csr_valid && csr_ready) begin
            port_ready_ff <= csr_port_ready;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ch_ff   <= pend_ch_in;
      pend_note_ff <= pend_note_in;
      if (req_accept) begin
         cmd_ch_ff   <= req_channel;
         cmd_note_ff <= req_note;
         cmd_vel_ff  <= req_velocity;
         cmd_off_ff  <= req_off_tick;
         cmd_now_ff  <= req_now_tick;
      end
      if (out_load) begin
         out_status_ff <= out_status;
         out_d1_ff     <= out_d1;
         out_d2_ff     <= out_d2;
         out_last_ff   <= out_last;
         out_ovf_ff    <= out_ovf;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status_byte    = out_status_ff;
   assign rsp_data_one       = out_d1_ff;
   assign rsp_data_two       = out_d2_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_queue_overflow = out_ovf_ff;

endmodule

// ===== src/mnos_checker.sv =====
// Port-level checker for the MIDI note-off scheduler, bound to the top level.
`include "assert_macros.svh"

module mnos_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_status_byte,
   input logic [6:0]  rsp_data_one,
   input logic [6:0]  rsp_data_two,
   input logic        rsp_last_of_run,
   input logic        rsp_queue_overflow
);

   // no result straight out of reset
   `CHK_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

   // a stalled result holds
   `CHK_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status_byte) && $stable(rsp_last_of_run),
      "stalled result changed")

   // an all-off request keeps the block busy while its messages go out
   `CHK_ASSERT(a_alloff_busy, clock, reset,
      req_valid && !req_stall && req_type == mnos_pkg::ReqAllOff |=> req_stall,
      "all-off request did not occupy the block")

   // controller messages carry controller 123, value 0, no overflow
   `CHK_ASSERT(a_cc_fields, clock, reset,
      rsp_valid && rsp_status_byte[7:4] == 4'hB |->
         rsp_data_one == mnos_pkg::CcAllOff && rsp_data_two == 7'd0 && !rsp_queue_overflow,
      "bad controller message")

   // note-off messages carry zero velocity and no overflow
   `CHK_ASSERT(a_off_fields, clock, reset,
      rsp_valid && rsp_status_byte[7:4] == 4'h8 |-> rsp_data_two == 7'd0 && !rsp_queue_overflow,
      "bad note-off message")

endmodule

bind midi_note_off_scheduler_core mnos_checker u_mnos_checker (.*);
